// ===== src/gpew_pkg.sv =====
// Package for the gene pair edge weight unit: payload types, pipeline item type, constants.
package gpew_pkg;

   typedef struct packed {
      logic signed [15:0] z_first;
      logic signed [15:0] z_second;
   } req_type;

   typedef struct packed {
      logic [16:0] edge_weight;
      logic        capped;
   } rsp_type;

   // Working set that travels down the pipeline with each item.
   typedef struct packed {
      logic               hi;
      logic               lo;
      logic               zneg;
      logic [14:0]        a;
      logic [29:0]        a2;
      logic [17:0]        den;
      logic [16:0]        t;
      logic signed [19:0] n;
      logic [26:0]        s;
      logic [22:0]        s2;
      logic [18:0]        s3;
      logic [14:0]        s4;
      logic [16:0]        d6;
      logic [30:0]        e;
      logic [20:0]        expo;
      logic [14:0]        b;
      logic [31:0]        lx;
      logic [20:0]        lg;
      logic [22:0]        l2;
   } item_type;

   localparam logic signed [15:0] ZLIMIT     = 16'sd24576;
   localparam logic [16:0]        WEIGHT_CAP = 17'd76800;
   localparam logic [13:0]        P_Q16      = 14'd15181;
   localparam logic [14:0]        C2_Q16     = 15'd26145;
   localparam logic [16:0]        LOG2E_Q16  = 17'd94548;
   localparam logic [15:0]        LOG10_2X2  = 16'd39456;
   localparam logic [21:0]        RECIP6     = 22'd2796203;
   localparam logic [19:0]        RECIP24    = 20'd699051;
   localparam logic signed [19:0] B5_Q16     = 20'sd87181;
   localparam logic signed [19:0] HORNER_ADD [5] =
      '{-20'sd119358, 20'sd116751, -20'sd23368, 20'sd20931, 20'sd0};

   // x*t/2^16, rounded half away from zero, t >= 0
   function automatic logic signed [19:0] mul_q16(input logic signed [19:0] x,
                                                  input logic [16:0] t);
      logic [18:0] mag;
      logic [35:0] prod;
      logic [19:0] r;
      mag  = x[19] ? 19'(-x) : x[18:0];
      prod = 36'(mag) * 36'(t);
      r    = 20'((prod + 36'd32768) >> 16);
      mul_q16 = x[19] ? -signed'(r) : signed'(r);
   endfunction

endpackage

// ===== src/gpew_recip.sv =====
// Pipelined restoring divider: t = round(2^32 / den), one quotient bit per stage.
module gpew_recip
   import gpew_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_vld,
   input  item_type in_item,
   output logic     out_vld,
   output item_type out_item
);

   localparam int STEPS = 17;

   logic [17:0] rem_ff [STEPS];
   logic [17:0] rem_in [STEPS];
   logic [16:0] q_ff   [STEPS];
   logic [16:0] q_in   [STEPS];
   item_type    it_ff  [STEPS];
   logic        vld_ff [STEPS];

   generate
      for (genvar k = 0; k < STEPS; k++) begin : g_step
         logic [17:0] rem_prev;
         logic [16:0] q_prev;
         item_type    it_prev;
         logic        vld_prev;
         logic [18:0] trial;
         logic        ge;

         if (k == 0) begin : g_first
            // numerator is 2^32 + den/2; its top part is 2^15
            assign rem_prev = 18'd32768;
            assign q_prev   = 17'd0;
            assign it_prev  = in_item;
            assign vld_prev = in_vld;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign q_prev   = q_ff[k-1];
            assign it_prev  = it_ff[k-1];
            assign vld_prev = vld_ff[k-1];
         end

         always_comb begin
            // next numerator bit is bit (16-k) of den/2
            trial     = {rem_prev, it_prev.den[STEPS-k]};
            ge        = trial >= {1'b0, it_prev.den};
            rem_in[k] = ge ? 18'(trial - {1'b0, it_prev.den}) : trial[17:0];
            q_in[k]   = q_prev | (ge ? (17'd1 << (STEPS - 1 - k)) : 17'd0);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (adv) begin
               vld_ff[k] <= vld_prev;
            end
            if (adv) begin
               rem_ff[k] <= rem_in[k];
               q_ff[k]   <= q_in[k];
               it_ff[k]  <= it_prev;
            end
         end
      end
   endgenerate

   always_comb begin
      out_item   = it_ff[STEPS-1];
      out_item.t = q_ff[STEPS-1];
   end
   assign out_vld = vld_ff[STEPS-1];

endmodule

// ===== src/gpew_log2.sv =====
// Pipelined log2 in Q16: normalize stage, then one fraction bit per squaring stage.
module gpew_log2
   import gpew_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_vld,
   input  item_type in_item,
   output logic     out_vld,
   output item_type out_item
);

   localparam int STEPS = 16;

   typedef struct packed {
      logic [4:0]  msb;
      logic [30:0] m;
      logic [15:0] frac;
   } lg_type;

   lg_type      nz_in;
   lg_type      nz_ff;
   item_type    nzit_ff;
   logic        nzv_ff;
   lg_type      lg_ff  [STEPS];
   lg_type      lg_in  [STEPS];
   item_type    it_ff  [STEPS];
   logic        vld_ff [STEPS];

   // normalize to Q30 in [1,2)
   always_comb begin
      logic [62:0] sh;
      nz_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (in_item.lx[i]) begin
            nz_in.msb = 5'(i);
         end
      end
      sh = 63'(in_item.lx) << (5'd30 - nz_in.msb);
      if (nz_in.msb == 5'd31) begin
         nz_in.m = in_item.lx[31:1];
      end else begin
         nz_in.m = sh[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nzv_ff <= 1'b0;
      end else if (adv) begin
         nzv_ff <= in_vld;
      end
      if (adv) begin
         nz_ff   <= nz_in;
         nzit_ff <= in_item;
      end
   end

   generate
      for (genvar k = 0; k < STEPS; k++) begin : g_sq
         lg_type      lg_prev;
         item_type    it_prev;
         logic        vld_prev;
         logic [61:0] sq;
         logic [31:0] top;

         if (k == 0) begin : g_first
            assign lg_prev  = nz_ff;
            assign it_prev  = nzit_ff;
            assign vld_prev = nzv_ff;
         end else begin : g_next
            assign lg_prev  = lg_ff[k-1];
            assign it_prev  = it_ff[k-1];
            assign vld_prev = vld_ff[k-1];
         end

         always_comb begin
            sq        = 62'(lg_prev.m) * 62'(lg_prev.m);
            top       = sq[61:30];
            lg_in[k]  = lg_prev;
            if (top[31]) begin
               lg_in[k].m                  = top[31:1];
               lg_in[k].frac[STEPS-1-k]    = 1'b1;
            end else begin
               lg_in[k].m = top[30:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (adv) begin
               vld_ff[k] <= vld_prev;
            end
            if (adv) begin
               lg_ff[k] <= lg_in[k];
               it_ff[k] <= it_prev;
            end
         end
      end
   endgenerate

   always_comb begin
      out_item    = it_ff[STEPS-1];
      out_item.lg = {lg_ff[STEPS-1].msb, lg_ff[STEPS-1].frac};
   end
   assign out_vld = vld_ff[STEPS-1];

endmodule

// ===== src/gene_pair_edge_weight_unit.sv =====
// Top level of the gene pair edge weight unit: -log10 of the squared normal tail.
//
//   channel | direction | handshake            | item
//   req_    | in        | req_valid/req_ready  | req_type: z_first, z_second (Q3.12)
//   rsp_    | out       | rsp_valid/rsp_ready  | rsp_type: edge_weight (Q9.8), capped
//
// One item per cycle enters while no result waits on rsp_ready; the pipeline
// is the 17-stage reciprocal divider and the 17-stage log2 unit, plus input,
// Horner, saturation, exp-squaring, tail and scaling stages.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline holds when a result waits on rsp_ready; req_ready drops
// in every cycle that the result waits, so no item is lost or repeated.
module gene_pair_edge_weight_unit
   import gpew_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     adv;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   rsp_type  rsp_data_in;

   // pipeline advances unless the output item is stalled
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- stage 0: min of the two, special ranges, |z|
   item_type s0_in, s0_ff;
   logic     v0_ff;

   always_comb begin
      logic signed [15:0] z;
      logic [15:0]        mag;
      z     = (req_data.z_first < req_data.z_second) ? req_data.z_first : req_data.z_second;
      mag   = z[15] ? 16'(-z) : 16'(z);
      s0_in      = '0;
      s0_in.hi   = z > ZLIMIT;
      s0_in.lo   = z < -ZLIMIT;
      s0_in.zneg = z[15];
      s0_in.a    = mag[14:0];
   end

   // ---- stage 1: a^2, the scaled exp series argument and the divisor 1 + p|z|
   item_type s1_in, s1_ff;
   logic     v1_ff;

   always_comb begin
      logic [28:0] pa;
      s1_in     = s0_ff;
      s1_in.a2  = 30'(s0_ff.a) * 30'(s0_ff.a);
      pa        = 29'(s0_ff.a) * 29'(P_Q16);
      s1_in.den = 18'd65536 + 18'((pa + 29'd2048) >> 12);
      s1_in.s   = s1_in.a2[29:3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
      end
      if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
      end
   end

   // ---- t = 1/(1+p|z|)
   item_type dv_item;
   logic     dv_vld;

   gpew_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (v1_ff),
      .in_item  (s1_ff),
      .out_vld  (dv_vld),
      .out_item (dv_item)
   );

   // ---- Horner, five stages; the exp series and the exponent term ride along
   item_type hn_ff [5];
   item_type hn_in [5];
   logic     hv_ff [5];

   generate
      for (genvar h = 0; h < 5; h++) begin : g_horner
         item_type hp;
         logic     hvp;

         if (h == 0) begin : g_first
            assign hp  = dv_item;
            assign hvp = dv_vld;
         end else begin : g_next
            assign hp  = hn_ff[h-1];
            assign hvp = hv_ff[h-1];
         end

         always_comb begin
            logic [53:0] p54;
            logic [49:0] p50;
            logic [45:0] p46;
            logic [40:0] p41;
            logic [34:0] p35;
            logic [32:0] esum;
            logic [46:0] p47;
            p54 = '0;
            p50 = '0;
            p46 = '0;
            p41 = '0;
            p35 = '0;
            esum = '0;
            p47 = '0;
            hn_in[h]   = hp;
            hn_in[h].n = mul_q16((h == 0) ? B5_Q16 : hp.n, hp.t) + HORNER_ADD[h];
            if (h == 0) begin
               p54 = 54'(hp.s) * 54'(hp.s);
               hn_in[h].s2 = p54[52:30];
            end else if (h == 1) begin
               p50 = 50'(hp.s2) * 50'(hp.s);
               hn_in[h].s3 = p50[48:30];
            end else if (h == 2) begin
               p46 = 46'(hp.s3) * 46'(hp.s);
               hn_in[h].s4 = p46[44:30];
               // s3/6 by reciprocal, exact over this range
               p41 = 41'(hp.s3) * 41'(RECIP6);
               hn_in[h].d6 = p41[40:24];
            end else if (h == 3) begin
               // s4/24 by reciprocal
               p35  = 35'(hp.s4) * 35'(RECIP24);
               esum = 33'd1073741824 + 33'(hp.s2[22:1]) + 33'(p35[34:24])
                    - 33'(hp.s) - 33'(hp.d6);
               hn_in[h].e = esum[30:0];
            end else begin
               p47 = 47'(hp.a2) * 47'(LOG2E_Q16) + 47'd16777216;
               hn_in[h].expo = p47[45:25];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               hv_ff[h] <= 1'b0;
            end else if (adv) begin
               hv_ff[h] <= hvp;
            end
            if (adv) begin
               hn_ff[h] <= hn_in[h];
            end
         end
      end
   endgenerate

   // ---- saturate the polynomial to raw [1, 131072], at most 2.0 in Q16
   item_type cl_in, cl_ff;
   logic     cv_ff;

   always_comb begin
      cl_in = hn_ff[4];
      if (hn_ff[4].n < 20'sd1) begin
         cl_in.n = 20'sd1;
      end else if (hn_ff[4].n > 20'sd131072) begin
         cl_in.n = 20'sd131072;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= 1'b0;
      end else if (adv) begin
         cv_ff <= hv_ff[4];
      end
      if (adv) begin
         cl_ff <= cl_in;
      end
   end

   // ---- exp(-a^2/2) = e^256, eight rounded squarings
   item_type sq_ff [8];
   item_type sq_in [8];
   logic     sv_ff [8];

   generate
      for (genvar q = 0; q < 8; q++) begin : g_square
         item_type qp;
         logic     qvp;

         if (q == 0) begin : g_first
            assign qp  = cl_ff;
            assign qvp = cv_ff;
         end else begin : g_next
            assign qp  = sq_ff[q-1];
            assign qvp = sv_ff[q-1];
         end

         always_comb begin
            logic [61:0] sq;
            sq         = 62'(qp.e) * 62'(qp.e) + 62'd536870912;
            sq_in[q]   = qp;
            sq_in[q].e = sq[60:30];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               sv_ff[q] <= 1'b0;
            end else if (adv) begin
               sv_ff[q] <= qvp;
            end
            if (adv) begin
               sq_ff[q] <= sq_in[q];
            end
         end
      end
   endgenerate

   // ---- density scale and log argument for the upper tail
   item_type sb_in, sb_ff;
   logic     bv_ff;

   always_comb begin
      logic [45:0] pb;
      logic [32:0] pc;
      pb       = 46'(C2_Q16) * 46'(sq_ff[7].e) + 46'd536870912;
      pc       = 33'(C2_Q16) * 33'(sq_ff[7].n[17:0]);
      sb_in    = sq_ff[7];
      sb_in.b  = pb[44:30];
      sb_in.lx = pc[31:0];
   end

   // ---- lower-tail reflection: tail = 1 - density*poly
   item_type st_in, st_ff;
   logic     tv_ff;

   always_comb begin
      logic [32:0] pn;
      logic [16:0] bn;
      logic [16:0] tail;
      pn    = 33'(sb_ff.b) * 33'(sb_ff.n[17:0]) + 33'd32768;
      bn    = pn[32:16];
      tail  = (bn < 17'd65536) ? 17'(17'd65536 - bn) : 17'd1;
      st_in = sb_ff;
      if (sb_ff.zneg) begin
         st_in.lx = 32'(tail);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= 1'b0;
         tv_ff <= 1'b0;
      end else if (adv) begin
         bv_ff <= sv_ff[7];
         tv_ff <= bv_ff;
      end
      if (adv) begin
         sb_ff <= sb_in;
         st_ff <= st_in;
      end
   end

   // ---- log2 of the argument
   item_type lg_item;
   logic     lg_vld;

   gpew_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (tv_ff),
      .in_item  (st_ff),
      .out_vld  (lg_vld),
      .out_item (lg_item)
   );

   // ---- -log2(tail) in Q16, clamped at zero
   item_type sl_in, sl_ff;
   logic     lv_ff;

   always_comb begin
      logic signed [24:0] l2s;
      if (lg_item.zneg) begin
         l2s = 25'sd1048576 - signed'(25'(lg_item.lg));
      end else begin
         l2s = 25'sd2097152 - signed'(25'(lg_item.lg)) + signed'(25'(lg_item.expo));
      end
      sl_in    = lg_item;
      sl_in.l2 = l2s[24] ? 23'd0 : l2s[22:0];
   end

   // ---- scale to -log10(tail^2) in Q9.8 and apply the caps
   always_comb begin
      logic [40:0] pw;
      logic [16:0] w;
      pw = 41'(sl_ff.l2) * 41'(LOG10_2X2) + 41'd8388608;
      w  = pw[40:24];
      if (sl_ff.hi || w >= WEIGHT_CAP || pw[40:24] != 17'(pw[40:24])) begin
         rsp_data_in.edge_weight = WEIGHT_CAP;
         rsp_data_in.capped      = 1'b1;
      end else if (sl_ff.lo) begin
         rsp_data_in.edge_weight = 17'd0;
         rsp_data_in.capped      = 1'b0;
      end else begin
         rsp_data_in.edge_weight = w;
         rsp_data_in.capped      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         lv_ff        <= lg_vld;
         rsp_valid_ff <= lv_ff;
      end
      if (adv) begin
         sl_ff       <= sl_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---- checks
   a_cap_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.capped |-> rsp_data.edge_weight == WEIGHT_CAP)
      else $error("capped item without the cap weight");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.edge_weight <= WEIGHT_CAP)
      else $error("edge weight above cap");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while output item stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== bench/gene_pair_edge_weight_checker.sv =====
// Checker for the gene pair edge weight unit: predicts each edge weight and compares.
`timescale 1ns / 100ps

module gene_pair_edge_weight_checker
   import gpew_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   rsp_type expected_weights[$];

   function automatic longint round_mul16(longint x, longint t);
      longint mag;
      mag = ((x < 0 ? -x : x) * t + 32768) >>> 16;
      return x < 0 ? -mag : mag;
   endfunction

   function automatic longint log2_fixed(longint x);
      longint m, frac;
      int msb;
      frac = 0;
      msb = 0;
      if (x < 1) x = 1;
      while (msb < 62 && (x >>> (msb + 1)) != 0) msb++;
      m = msb > 30 ? x >>> (msb - 30) : x <<< (30 - msb);
      for (int k = 15; k >= 0; k--) begin
         m = (m * m) >>> 30;
         if (m >= (longint'(1) << 31)) begin
            m = m >>> 1;
            frac |= longint'(1) << k;
         end
      end
      return (longint'(msb) << 16) + frac;
   endfunction

   function automatic rsp_type predict_weight(req_type r);
      rsp_type o;
      longint z, a, a2, den, t, n, l2, w, expo, s, s2, s3, s4, e, b, bn, tl;
      z = r.z_first < r.z_second ? r.z_first : r.z_second;
      if (z > 24576) begin
         o.edge_weight = WEIGHT_CAP;
         o.capped = 1'b1;
         return o;
      end
      if (z < -24576) begin
         o.edge_weight = '0;
         o.capped = 1'b0;
         return o;
      end
      a = z < 0 ? -z : z;
      a2 = a * a;
      den = 65536 + ((15181 * a + 2048) >>> 12);
      t = ((longint'(1) << 32) + den / 2) / den;
      n = 87181;
      n = round_mul16(n, t) - 119358;
      n = round_mul16(n, t) + 116751;
      n = round_mul16(n, t) - 23368;
      n = round_mul16(n, t) + 20931;
      n = round_mul16(n, t);
      if (n < 1) n = 1;
      if (n > 131072) n = 131072;
      if (z >= 0) begin
         expo = (a2 * 94548 + (longint'(1) << 24)) >>> 25;
         l2 = (longint'(32) << 16) - log2_fixed(26145 * n) + expo;
      end else begin
         s = a2 >>> 3;
         s2 = (s * s) >>> 30;
         s3 = (s2 * s) >>> 30;
         s4 = (s3 * s) >>> 30;
         e = (longint'(1) << 30) + s2 / 2 + s4 / 24 - s - s3 / 6;
         for (int k = 0; k < 8; k++) e = (e * e + (longint'(1) << 29)) >>> 30;
         b = (26145 * e + (longint'(1) << 29)) >>> 30;
         bn = (b * n + 32768) >>> 16;
         tl = bn < 65536 ? 65536 - bn : 1;
         l2 = (longint'(16) << 16) - log2_fixed(tl);
      end
      if (l2 < 0) l2 = 0;
      w = (l2 * 2 * 19728 + (longint'(1) << 23)) >>> 24;
      o.capped = w >= 76800;
      o.edge_weight = o.capped ? WEIGHT_CAP : 17'(w);
      return o;
   endfunction

   assign pending_count = expected_weights.size();

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) expected_weights.push_back(predict_weight(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_weights.size() == 0) begin
               $error("result with nothing expected: %0d", rsp_data.edge_weight);
               errs++;
            end else begin
               want = expected_weights.pop_front();
               if (want.edge_weight !== rsp_data.edge_weight) begin
                  $error("edge_weight expected %0d actual %0d",
                         want.edge_weight, rsp_data.edge_weight);
                  errs++;
               end
               if (want.capped !== rsp_data.capped) begin
                  $error("capped expected %0d actual %0d", want.capped, rsp_data.capped);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== bench/gene_pair_edge_weight_unit_tb.sv =====
// Testbench top for the gene pair edge weight unit: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module gene_pair_edge_weight_unit_tb;
   import gpew_pkg::*;

   localparam int LATENCY = 54;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   bit      long_hold = 1'b0;   // receiver held off for a long stretch
   bit      hold_done = 1'b0;

   // directed z pairs: extremes, the four boundaries, zero, sign flips
   localparam logic signed [15:0] DIRECTED [24] = '{
      16'sh7FFF, -16'sh8000, 16'sd24576, -16'sd24576, 16'sd24577, -16'sd24577,
      16'sd0, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096, 16'sd8192, -16'sd8192,
      16'sd12288, -16'sd12288, 16'sd20000, -16'sd20000, 16'sh5555, -16'sh5556,
      16'sd2, -16'sd2, 16'sh2AAA, 16'sd100, -16'sd100};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   gene_pair_edge_weight_unit dut (.*);

   gene_pair_edge_weight_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int gap_length();
      // mostly short gaps, now and then a long one
      if ($urandom_range(9) < 6) return 0;
      if ($urandom_range(9) < 9) return $urandom_range(3);
      return $urandom_range(40);
   endfunction

   function automatic logic signed [15:0] random_z();
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(49152)) - 16'sd24576;
         2: return 16'($urandom_range(200)) + 16'sd24476;
         3: return -(16'($urandom_range(200)) + 16'sd24476);
         default: return 16'($urandom_range(8192)) - 16'sd4096;
      endcase
   endfunction

   // result side: random stalls, plus one long hold-off
   always @(posedge clock) begin
      int wait_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         wait_left = 0;
      end else if (long_hold && !hold_done) begin
         rsp_ready <= 1'b0;
         for (int k = 0; k < 300; k++) @(posedge clock);
         hold_done = 1'b1;
         rsp_ready <= 1'b1;
      end else if (wait_left > 0) begin
         wait_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         wait_left = gap_length();
      end
   end

   task automatic send_item(input logic signed [15:0] z1, input logic signed [15:0] z2);
      req_valid <= 1'b1;
      req_data.z_first  <= z1;
      req_data.z_second <= z2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 24; i++) begin
         send_item(DIRECTED[i], DIRECTED[(i * 7 + 3) % 24]);
         send_item(DIRECTED[i], DIRECTED[i]);
      end
      // sender pauses until everything is drained
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      // receiver holds off while items keep coming, filling the pipeline
      long_hold = 1'b1;
      for (int i = 0; i < 200; i++) send_item(random_z(), random_z());
      for (int i = 0; i < 1200; i++) begin
         send_item(random_z(), random_z());
         idle_gap(gap_length());
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
